[hdl/mtc_pkg.sv]
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, register codes and helpers for the meson trace contraction.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] GAMMA_PERM_RESET  = 8'd228;
  localparam logic [7:0] GAMMA_PHASE_RESET = 8'd0;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_FORWARD = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SINK_PERM     = 3'd0,
    CFG_SINK_PHASE    = 3'd1,
    CFG_SOURCE_PERM   = 3'd2,
    CFG_SOURCE_PHASE  = 3'd3,
    CFG_CHIRAL_PERM   = 3'd4,
    CFG_CHIRAL_PHASE  = 3'd5
  } cfg_idx_t;

  // Combined phase code: how the conjugated product enters the sum.
  typedef enum logic [1:0] {
    PH_SUB      = 2'd0,
    PH_ADD_NEGI = 2'd1,
    PH_ADD      = 2'd2,
    PH_ADD_POSI = 2'd3
  } phase_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         spin_row;
    logic [1:0]         spin_col;
    logic [3:0]         color_index;
    logic signed [23:0] value_re;
    logic signed [23:0] value_im;
    logic               last;
  } elem_t;

  typedef struct packed {
    logic signed [63:0] trace_re;
    logic signed [63:0] trace_im;
  } trace_t;

  // Control that travels with a forward item down the pipeline.
  typedef struct packed {
    logic   valid;
    logic   add;
    logic   last;
    phase_t ph;
  } mtc_ctl_t;

  // Two-bit field k of a gamma register, row 0 in the low bits.
  function automatic logic [1:0] field2(input logic [7:0] r, input logic [1:0] k);
    logic [7:0] s;
    s = r >> {k, 1'b0};
    return s[1:0];
  endfunction

endpackage

[hdl/mtc_store.sv]
// ----------------------------------------------------------------------------
// mtc_store
// Backward matrix store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtc_store #(
  parameter int DEPTH = 144,
  parameter int AW    = 8,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/mtc_cmac.sv]
// ----------------------------------------------------------------------------
// mtc_cmac
// Conjugate complex multiply: four partial products, then the real and
// imaginary combinations of conj(B) * F, each behind its own register.
// ----------------------------------------------------------------------------
module mtc_cmac import mtc_pkg::*; #(
  parameter int ELEM_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  mtc_ctl_t                     ctl_in,
  input  logic signed [ELEM_WIDTH-1:0] b_re,
  input  logic signed [ELEM_WIDTH-1:0] b_im,
  input  logic signed [ELEM_WIDTH-1:0] f_re,
  input  logic signed [ELEM_WIDTH-1:0] f_im,
  output mtc_ctl_t                     ctl_out,
  output logic signed [2*ELEM_WIDTH:0] pre,
  output logic signed [2*ELEM_WIDTH:0] pim
);

  localparam int MW = 2 * ELEM_WIDTH;
  localparam int PW = MW + 1;

  mtc_ctl_t             ctl_mul;
  logic signed [MW-1:0] p_rr, p_ii, p_ri, p_ir;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mul <= '0;
      ctl_out <= '0;
    end else if (advance) begin
      ctl_mul <= ctl_in;
      ctl_out <= ctl_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_rr <= b_re * f_re;
      p_ii <= b_im * f_im;
      p_ri <= b_re * f_im;
      p_ir <= b_im * f_re;
      pre  <= PW'(p_rr) + PW'(p_ii);
      pim  <= PW'(p_ri) - PW'(p_ir);
    end
  end

endmodule

[hdl/mtc_accum.sv]
// ----------------------------------------------------------------------------
// mtc_accum
// Phase-rotated accumulation of the trace and the output register.
// ----------------------------------------------------------------------------
module mtc_accum import mtc_pkg::*; #(
  parameter int PW = 49
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mtc_ctl_t             ctl,
  input  logic signed [PW-1:0] pre,
  input  logic signed [PW-1:0] pim,
  input  logic                 trace_stall,
  output logic                 trace_valid,
  output trace_t               trace,
  output logic                 freeze
);

  logic signed [63:0] acc_re, acc_im;
  logic signed [63:0] nxt_re, nxt_im;
  logic signed [63:0] ext_re, ext_im;
  logic               consume;

  assign ext_re = 64'(pre);
  assign ext_im = 64'(pim);

  // A finished trace cannot leave while the output register is held.
  assign freeze  = ctl.valid && ctl.last && trace_valid && trace_stall;
  assign consume = ctl.valid && !freeze;

  always_comb begin
    nxt_re = acc_re;
    nxt_im = acc_im;
    if (ctl.add) begin
      case (ctl.ph)
        PH_SUB: begin
          nxt_re = acc_re - ext_re;
          nxt_im = acc_im - ext_im;
        end
        PH_ADD_NEGI: begin
          nxt_re = acc_re + ext_im;
          nxt_im = acc_im - ext_re;
        end
        PH_ADD: begin
          nxt_re = acc_re + ext_re;
          nxt_im = acc_im + ext_im;
        end
        PH_ADD_POSI: begin
          nxt_re = acc_re - ext_im;
          nxt_im = acc_im + ext_re;
        end
        default: begin
          nxt_re = acc_re;
          nxt_im = acc_im;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re      <= '0;
      acc_im      <= '0;
      trace_valid <= 1'b0;
    end else begin
      if (consume && ctl.last) begin
        acc_re      <= '0;
        acc_im      <= '0;
        trace_valid <= 1'b1;
      end else begin
        if (consume) begin
          acc_re <= nxt_re;
          acc_im <= nxt_im;
        end
        if (!trace_stall) begin
          trace_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && ctl.last) begin
      trace.trace_re <= nxt_re;
      trace.trace_im <= nxt_im;
    end
  end

endmodule

[hdl/meson_trace_contraction_unit.sv]
// ----------------------------------------------------------------------------
// meson_trace_contraction_unit
// Meson two-point contraction -Tr[Gsnk (G5 B G5)^dagger Gsrc F] in fixed point.
// ----------------------------------------------------------------------------
// Usage:
// The elem channel (elem_valid, elem_stall, elem) carries one item per
// accepted handshake. A load item writes one element of the backward matrix
// into an on-chip store; a forward item reads the permuted backward element,
// multiplies its conjugate by the forward value and adds the product, turned
// by the combined gamma phase, into the trace accumulator.
// A forward item with last set closes the trace: it appears on the trace
// channel (trace_valid, trace_stall, trace) after the read stage, the
// product and sum registers and the accumulator, and the accumulator starts
// again from zero. Throughput is one item per cycle for loads and forwards
// alike while elem_stall is low; the store has one write and one read port,
// and a load is visible to a forward item accepted in the very next cycle.
// The gamma registers are written through cfg_we, cfg_index and cfg_data
// while the block is idle; the user must keep to this, the block does not enforce it.
// Reset clears the accumulator, the pipeline control, the output valid and sets
// every gamma to the identity. The store is not cleared: reading an entry
// that was never loaded gives an undefined value.
// When the receiver stalls, the finished trace waits in the output register
// and items keep flowing; elem_stall rises only when a second finished trace
// reaches the accumulator while the first one is still held.
// ----------------------------------------------------------------------------
module meson_trace_contraction_unit import mtc_pkg::*; #(
  parameter int SPIN_DIM   = 4,
  parameter int COLOR_DIM  = 3,
  parameter int ELEM_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  elem_valid,
  output logic                  elem_stall,
  input  elem_t                 elem,
  output logic                  trace_valid,
  input  logic                  trace_stall,
  output trace_t                trace,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CC_DIM = COLOR_DIM * COLOR_DIM;
  localparam int DEPTH  = SPIN_DIM * SPIN_DIM * CC_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int DW     = 2 * ELEM_WIDTH;
  localparam int PW     = DW + 1;

  localparam logic [2:0] SPIN_LIM  = 3'(SPIN_DIM);
  localparam logic [4:0] COLOR_LIM = 5'(CC_DIM);

  // Gamma registers: four 2-bit column indices or phase codes each.
  logic [7:0] sink_perm, sink_phase;
  logic [7:0] source_perm, source_phase;
  logic [7:0] chiral_perm, chiral_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      sink_perm    <= GAMMA_PERM_RESET;
      sink_phase   <= GAMMA_PHASE_RESET;
      source_perm  <= GAMMA_PERM_RESET;
      source_phase <= GAMMA_PHASE_RESET;
      chiral_perm  <= GAMMA_PERM_RESET;
      chiral_phase <= GAMMA_PHASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SINK_PERM:    sink_perm    <= cfg_data;
        CFG_SINK_PHASE:   sink_phase   <= cfg_data;
        CFG_SOURCE_PERM:  source_perm  <= cfg_data;
        CFG_SOURCE_PHASE: source_phase <= cfg_data;
        CFG_CHIRAL_PERM:  chiral_perm  <= cfg_data;
        CFG_CHIRAL_PHASE: chiral_phase <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Decode of the incoming item. The row index j selects col2 through the
  // source and chiral gammas; the column index i selects col1 through the
  // sink and chiral gammas.
  logic                         freeze, advance, accept;
  logic                         in_range, cols_ok;
  logic [1:0]                   col1, col2, ph_sum;
  logic signed [ELEM_WIDTH-1:0] v_re, v_im;
  logic [AW-1:0]                waddr, raddr;
  logic                         st_we, st_re;
  logic [DW-1:0]                rdata;

  assign advance    = !freeze;
  assign elem_stall = freeze;
  assign accept     = elem_valid && !freeze;

  assign in_range = ({1'b0, elem.spin_row} < SPIN_LIM) &&
                    ({1'b0, elem.spin_col} < SPIN_LIM) &&
                    ({1'b0, elem.color_index} < COLOR_LIM);

  assign col2 = field2(source_perm, field2(chiral_perm, elem.spin_row));
  assign col1 = field2(chiral_perm, field2(sink_perm, elem.spin_col));

  // Column indices past the spin dimension contribute nothing.
  assign cols_ok = ({1'b0, col1} < SPIN_LIM) && ({1'b0, col2} < SPIN_LIM);

  // Phase codes add modulo four.
  assign ph_sum = field2(sink_phase, elem.spin_col) + field2(chiral_phase, col1) +
                  field2(chiral_phase, col2) + field2(source_phase, col2);

  // The element parts are cut or sign-extended to ELEM_WIDTH bits.
  assign v_re = ELEM_WIDTH'(elem.value_re);
  assign v_im = ELEM_WIDTH'(elem.value_im);

  assign waddr = AW'((int'(elem.spin_row) * SPIN_DIM + int'(elem.spin_col)) * CC_DIM +
                     int'(elem.color_index));
  assign raddr = AW'((int'(col2) * SPIN_DIM + int'(col1)) * CC_DIM +
                     int'(elem.color_index));

  assign st_we = accept && (elem.kind == KIND_LOAD) && in_range;
  assign st_re = accept && (elem.kind == KIND_FORWARD);

  mtc_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (waddr),
    .wdata ({v_re, v_im}),
    .re    (st_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read stage: the forward value and its control wait for the store data.
  mtc_ctl_t                     ctl_rd;
  logic signed [ELEM_WIDTH-1:0] f_re, f_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_rd <= '0;
    end else if (advance) begin
      ctl_rd.valid <= st_re;
      ctl_rd.add   <= in_range && cols_ok;
      ctl_rd.last  <= elem.last;
      ctl_rd.ph    <= phase_t'(ph_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (st_re) begin
      f_re <= v_re;
      f_im <= v_im;
    end
  end

  mtc_ctl_t             ctl_acc;
  logic signed [PW-1:0] pre, pim;

  mtc_cmac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_cmac (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ctl_in  (ctl_rd),
    .b_re    ($signed(rdata[DW-1:ELEM_WIDTH])),
    .b_im    ($signed(rdata[ELEM_WIDTH-1:0])),
    .f_re    (f_re),
    .f_im    (f_im),
    .ctl_out (ctl_acc),
    .pre     (pre),
    .pim     (pim)
  );

  mtc_accum #(
    .PW (PW)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl_acc),
    .pre         (pre),
    .pim         (pim),
    .trace_stall (trace_stall),
    .trace_valid (trace_valid),
    .trace       (trace),
    .freeze      (freeze)
  );

endmodule

[hdl/mtc_checker.sv]
// ----------------------------------------------------------------------------
// mtc_checker
// Port-level checks of the meson trace contraction unit.
// ----------------------------------------------------------------------------
module mtc_checker import mtc_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   elem_valid,
  input logic   elem_stall,
  input elem_t  elem,
  input logic   trace_valid,
  input logic   trace_stall,
  input trace_t trace
);

  // A held trace stays valid.
  a_trace_hold: assert property (@(posedge clk) disable iff (rst)
    trace_valid && trace_stall |=> trace_valid)
    else $error("trace item dropped while stalled");

  // A held trace keeps its value.
  a_trace_stable: assert property (@(posedge clk) disable iff (rst)
    trace_valid && trace_stall |=> $stable(trace))
    else $error("trace payload changed while stalled");

  // Input backpressure only comes from a stalled, full output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    elem_stall |-> trace_valid && trace_stall)
    else $error("input stalled without a held trace");

  // A fresh trace follows an accepted closing forward item through the read,
  // product and sum registers when the pipeline has not been held in between.
  a_trace_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(trace_valid) && !$past(elem_stall, 1) && !$past(elem_stall, 2) &&
      !$past(elem_stall, 3) && !$past(elem_stall, 4) |->
      $past(elem_valid && !elem_stall && elem.kind == KIND_FORWARD && elem.last, 4))
    else $error("trace item without a closing forward item");

  // Nothing is shown right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !trace_valid)
    else $error("trace valid after reset");

endmodule

bind meson_trace_contraction_unit mtc_checker u_mtc_checker (
  .clk         (clk),
  .rst         (rst),
  .elem_valid  (elem_valid),
  .elem_stall  (elem_stall),
  .elem        (elem),
  .trace_valid (trace_valid),
  .trace_stall (trace_stall),
  .trace       (trace)
);
